/* sv/lsbc_pkg.sv */
package lsbc_pkg;

	localparam int CW    = 32;            // coordinate width
	localparam int DW    = CW + 1;        // difference / offset width
	localparam int PFB   = 24;            // parameter fraction bits
	localparam int TW    = PFB + 1;       // parameter width, holds 1.0 and 1.0 + 1 lsb
	localparam int PW    = TW + 1 + DW;   // signed product width
	localparam int NAXIS = 3;
	localparam int NLANE = 2 * NAXIS;
	localparam int NREG  = 6;

	localparam int STEPS_PER_STAGE = 4;
	localparam int DIV_STAGES      = PFB / STEPS_PER_STAGE;

	// stage numbers
	localparam int ST_DIV0 = 3;
	localparam int ST_COMB = ST_DIV0 + DIV_STAGES;
	localparam int ST_MUL  = ST_COMB + 1;
	localparam int ST_OUT  = ST_COMB + 2;
	localparam int NSTAGE  = ST_OUT;

	localparam logic [CW-1:0] REJECT = -32'sd999;
	localparam logic [TW-1:0] T_ONE  = {1'b1, {PFB{1'b0}}};
	localparam logic [TW-1:0] T_OVER = {1'b1, {(PFB-1){1'b0}}, 1'b1};

	typedef enum logic [2:0] {
		REG_X_LOW  = 3'd0,
		REG_X_HIGH = 3'd1,
		REG_Y_LOW  = 3'd2,
		REG_Y_HIGH = 3'd3,
		REG_Z_LOW  = 3'd4,
		REG_Z_HIGH = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [CW-1:0] start_x;
		logic signed [CW-1:0] start_y;
		logic signed [CW-1:0] start_z;
		logic signed [CW-1:0] end_x;
		logic signed [CW-1:0] end_y;
		logic signed [CW-1:0] end_z;
	} seg_in_t;

	typedef struct packed {
		logic                 visible;
		logic signed [CW-1:0] clip_start_x;
		logic signed [CW-1:0] clip_start_y;
		logic signed [CW-1:0] clip_start_z;
		logic signed [CW-1:0] clip_end_x;
		logic signed [CW-1:0] clip_end_y;
		logic signed [CW-1:0] clip_end_z;
	} seg_out_t;

	// start point and direction per axis
	typedef struct packed {
		logic [NAXIS-1:0][CW-1:0] s;
		logic [NAXIS-1:0][DW-1:0] d;
	} geom_t;

	// one boundary test in flight through the divider
	typedef struct packed {
		logic          pzero;
		logic          pneg;
		logic          qneg;
		logic          big;    // |q| > |p|
		logic          eq;     // |q| == |p|
		logic [DW-1:0] rem;
		logic [DW-1:0] den;
		logic [PFB-1:0] quo;
	} lane_t;

	typedef struct packed {
		logic          vis;
		logic [TW-1:0] t_in;
		logic [TW-1:0] t_out;
	} tparam_t;

endpackage

/* sv/lsbc_div_stage.sv */
module lsbc_div_stage import lsbc_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  lane_t [NLANE-1:0]       lanes_in,
	output lane_t [NLANE-1:0]       lanes_out
);

	lane_t [NLANE-1:0] nxt;

	// restoring division, STEPS_PER_STAGE quotient bits per stage
	always_comb begin
		logic [DW:0] r2;
		nxt = lanes_in;
		for (int l = 0; l < NLANE; l++) begin
			for (int k = 0; k < STEPS_PER_STAGE; k++) begin
				r2 = {nxt[l].rem, 1'b0};
				if (r2 >= {1'b0, nxt[l].den}) begin
					r2 = r2 - {1'b0, nxt[l].den};
					nxt[l].quo = {nxt[l].quo[PFB-2:0], 1'b1};
				end else begin
					nxt[l].quo = {nxt[l].quo[PFB-2:0], 1'b0};
				end
				nxt[l].rem = r2[DW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lanes_out <= nxt;
		end
	end

endmodule

/* sv/lsbc_combine.sv */
module lsbc_combine import lsbc_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  lane_t [NLANE-1:0] lanes_in,
	output tparam_t           res_s9
);

	tparam_t nxt;

	always_comb begin
		logic          fail;
		logic [TW-1:0] cand;
		fail = 1'b0;
		nxt.t_in = '0;
		nxt.t_out = T_ONE;
		for (int l = 0; l < NLANE; l++) begin
			cand = '0;
			if (lanes_in[l].pzero) begin
				if (lanes_in[l].qneg) fail = 1'b1;
			end else if (lanes_in[l].pneg) begin
				// entry: only a negative offset can raise t_in; round up
				if (lanes_in[l].qneg) begin
					if (lanes_in[l].big) cand = T_OVER;
					else if (lanes_in[l].eq) cand = T_ONE;
					else cand = TW'(lanes_in[l].quo) + TW'(lanes_in[l].rem != '0);
					if (cand > nxt.t_in) nxt.t_in = cand;
				end
			end else begin
				// exit: negative offset means t_out < 0; round down
				if (lanes_in[l].qneg) begin
					fail = 1'b1;
				end else if (!lanes_in[l].big && !lanes_in[l].eq) begin
					cand = TW'(lanes_in[l].quo);
					if (cand < nxt.t_out) nxt.t_out = cand;
				end
			end
		end
		nxt.vis = !fail && (nxt.t_in <= nxt.t_out);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s9 <= nxt;
		end
	end

endmodule

/* sv/lsbc_point.sv */
module lsbc_point import lsbc_pkg::*; (
	input  logic     clk,
	input  logic     en_mul,
	input  logic     en_out,
	input  tparam_t  tp,
	input  geom_t    geom,
	output seg_out_t result
);

	logic signed [PW-1:0]     prod_s10 [NLANE];
	logic [NAXIS-1:0][CW-1:0] start_s10;
	logic                     vis_s10;
	logic [NLANE-1:0][CW-1:0] pt;
	seg_out_t                 out_s11;

	always_ff @(posedge clk) begin
		if (en_mul) begin
			for (int j = 0; j < NAXIS; j++) begin
				prod_s10[j] <= $signed({1'b0, tp.t_in}) * $signed(geom.d[j]);
				prod_s10[j+NAXIS] <= $signed({1'b0, tp.t_out}) * $signed(geom.d[j]);
			end
			start_s10 <= geom.s;
			vis_s10 <= tp.vis;
		end
	end

	// round to nearest, ties up, then offset from start
	always_comb begin
		logic signed [PW-1:0] h;
		for (int l = 0; l < NLANE; l++) begin
			h = prod_s10[l] + $signed(PW'(1) << (PFB - 1));
			h = h >>> PFB;
			pt[l] = start_s10[l % NAXIS] + h[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			out_s11.visible <= vis_s10;
			out_s11.clip_start_x <= vis_s10 ? pt[0] : REJECT;
			out_s11.clip_start_y <= vis_s10 ? pt[1] : REJECT;
			out_s11.clip_start_z <= vis_s10 ? pt[2] : REJECT;
			out_s11.clip_end_x <= vis_s10 ? pt[3] : REJECT;
			out_s11.clip_end_y <= vis_s10 ? pt[4] : REJECT;
			out_s11.clip_end_z <= vis_s10 ? pt[5] : REJECT;
		end
	end

	assign result = out_s11;

endmodule

/* sv/line_segment_box_clipper_3d.sv */
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | in_data   (seg_in_t)
// out     | output    | out_valid / out_ready | out_data  (seg_out_t)
// cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// Pipeline stages: difference stage, magnitude stage, six divider stages
// (four quotient bits each), parameter combine, multiply, round and add.
// One segment per cycle unless the output stalls; the per-stage handshake holds the flow then.
// Each stage holds its transaction while the next one is full and stalled, so bubbles
// collapse and a stall at the output drops or repeats nothing.
// arst_n clears the valid bits and the box registers.
module line_segment_box_clipper_3d import lsbc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  seg_in_t       in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output seg_out_t      out_data,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [CW-1:0] cfg_data
);

	logic [CW-1:0]            box_q [NREG];
	logic [NSTAGE:1]          vld_q;
	logic [NSTAGE:1]          adv;
	geom_t                    geom_s [1:ST_COMB];
	logic [NLANE-1:0][DW-1:0] q_s1;
	lane_t [NLANE-1:0]        lanes_s [2:ST_COMB-1];
	lane_t [NLANE-1:0]        lanes_nxt;
	tparam_t                  comb_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NREG; i++) box_q[i] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_X_LOW:  box_q[REG_X_LOW] <= cfg_data;
				REG_X_HIGH: box_q[REG_X_HIGH] <= cfg_data;
				REG_Y_LOW:  box_q[REG_Y_LOW] <= cfg_data;
				REG_Y_HIGH: box_q[REG_Y_HIGH] <= cfg_data;
				REG_Z_LOW:  box_q[REG_Z_LOW] <= cfg_data;
				REG_Z_HIGH: box_q[REG_Z_HIGH] <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage may load when it is empty or its contents move on
	always_comb begin
		adv[NSTAGE] = !vld_q[NSTAGE] || out_ready;
		for (int k = NSTAGE - 1; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) vld_q[1] <= in_valid;
			for (int k = 2; k <= NSTAGE; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign in_ready = adv[1];
	assign out_valid = vld_q[NSTAGE];

	// stage 1: directions and offsets; geometry then rides along to the multiply
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			geom_s[1].s[0] <= in_data.start_x;
			geom_s[1].s[1] <= in_data.start_y;
			geom_s[1].s[2] <= in_data.start_z;
			geom_s[1].d[0] <= {in_data.end_x[CW-1], in_data.end_x}
				- {in_data.start_x[CW-1], in_data.start_x};
			geom_s[1].d[1] <= {in_data.end_y[CW-1], in_data.end_y}
				- {in_data.start_y[CW-1], in_data.start_y};
			geom_s[1].d[2] <= {in_data.end_z[CW-1], in_data.end_z}
				- {in_data.start_z[CW-1], in_data.start_z};
			q_s1[0] <= {in_data.start_x[CW-1], in_data.start_x}
				- {box_q[REG_X_LOW][CW-1], box_q[REG_X_LOW]};
			q_s1[1] <= {box_q[REG_X_HIGH][CW-1], box_q[REG_X_HIGH]}
				- {in_data.start_x[CW-1], in_data.start_x};
			q_s1[2] <= {in_data.start_y[CW-1], in_data.start_y}
				- {box_q[REG_Y_LOW][CW-1], box_q[REG_Y_LOW]};
			q_s1[3] <= {box_q[REG_Y_HIGH][CW-1], box_q[REG_Y_HIGH]}
				- {in_data.start_y[CW-1], in_data.start_y};
			q_s1[4] <= {in_data.start_z[CW-1], in_data.start_z}
				- {box_q[REG_Z_LOW][CW-1], box_q[REG_Z_LOW]};
			q_s1[5] <= {box_q[REG_Z_HIGH][CW-1], box_q[REG_Z_HIGH]}
				- {in_data.start_z[CW-1], in_data.start_z};
		end
		for (int k = 2; k <= ST_COMB; k++) begin
			if (adv[k]) geom_s[k] <= geom_s[k-1];
		end
	end

	// stage 2: magnitudes, signs; low test has p = -d, high test p = d
	always_comb begin
		logic [DW-1:0] d;
		logic [DW-1:0] ap;
		logic [DW-1:0] aq;
		for (int l = 0; l < NLANE; l++) begin
			d = geom_s[1].d[l/2];
			ap = d[DW-1] ? -d : d;
			aq = q_s1[l][DW-1] ? -q_s1[l] : q_s1[l];
			lanes_nxt[l].pzero = (d == '0);
			lanes_nxt[l].pneg = (l % 2 == 0) ? (!d[DW-1] && d != '0) : d[DW-1];
			lanes_nxt[l].qneg = q_s1[l][DW-1];
			lanes_nxt[l].big = aq > ap;
			lanes_nxt[l].eq = aq == ap;
			lanes_nxt[l].rem = aq;
			lanes_nxt[l].den = ap;
			lanes_nxt[l].quo = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			lanes_s[2] <= lanes_nxt;
		end
	end

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		lsbc_div_stage u_div (
			.clk       (clk),
			.en        (adv[ST_DIV0+i]),
			.lanes_in  (lanes_s[ST_DIV0+i-1]),
			.lanes_out (lanes_s[ST_DIV0+i])
		);
	end

	lsbc_combine u_comb (
		.clk      (clk),
		.en       (adv[ST_COMB]),
		.lanes_in (lanes_s[ST_COMB-1]),
		.res_s9   (comb_s9)
	);

	lsbc_point u_point (
		.clk    (clk),
		.en_mul (adv[ST_MUL]),
		.en_out (adv[ST_OUT]),
		.tp     (comb_s9),
		.geom   (geom_s[ST_COMB]),
		.result (out_data)
	);

	a_reject_sentinel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.visible |->
			out_data.clip_start_x == REJECT && out_data.clip_end_z == REJECT)
		else $error("rejected segment without sentinel");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[NSTAGE] |-> in_ready)
		else $error("input stalled with empty output stage");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[1])
		else $error("accepted transaction lost at stage 1");

	a_param_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[ST_COMB] && comb_s9.vis |->
			comb_s9.t_in <= comb_s9.t_out && comb_s9.t_out <= T_ONE)
		else $error("visible segment with bad parameters");

endmodule
